// File: rtl/core/kmp_pkg.sv
package kmp_pkg;

    // Command codes carried on the input channel
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // Scan limit after reset: no limit in practice
    localparam logic [31:0] SCAN_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        found;
        logic [31:0] match_position;
        logic        pattern_overflow;
    } t_result;

endpackage

// File: rtl/core/kmp_if.sv
interface kmp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, cmd, data_byte, last, input ready);
    modport sink   (input valid, cmd, data_byte, last, output ready);
endinterface

interface kmp_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_position;
    logic        pattern_overflow;

    modport source (output valid, found, match_position, pattern_overflow, input ready);
    modport sink   (input valid, found, match_position, pattern_overflow, output ready);
endinterface

interface kmp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/kmp_ram.sv
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/kmp_engine.sv
module kmp_engine
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int AW          = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmp_in_if.sink        i_in,
    input  logic [31:0]   i_max_scan,
    input  logic          i_slot_free,
    output logic          o_res_valid,
    output t_result       o_res,
    output logic          o_rd_en,
    output logic [AW-1:0] o_pat_rd_addr,
    input  logic [7:0]    i_pat_rd_data,
    output logic [AW-1:0] o_fail_rd_addr,
    input  logic [AW-1:0] i_fail_rd_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_pat,
    output logic [AW-1:0] o_wr_fail
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [AW-1:0] r_border, n_border;
    logic [AW-1:0] r_matched, n_matched;
    logic [31:0]   r_offset, n_offset;
    logic          r_run_done, n_run_done;
    logic          r_ovf, n_ovf;
    logic          r_open, n_open;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_cmd, n_cmd;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;
    t_result       r_res, n_res;

    logic [LW-1:0] w_len_eff;
    logic [AW-1:0] w_i0;
    logic          w_pat_walk;
    logic          w_txt_walk;
    logic          w_imm_emit;
    logic          w_eq;
    logic          w_mis;
    logic [LW-1:0] w_inc;
    logic          w_hit;
    logic          w_walk_emit;
    logic [31:0]   w_pos;

    assign i_in.ready = (r_state == S_IDLE);

    // Decode of the incoming beat and of the walk step
    always_comb begin
        w_len_eff  = r_open ? r_len : '0;
        w_i0       = (i_in.cmd == CMD_PATTERN) ? (r_open ? r_border : '0) : r_matched;
        w_pat_walk = (i_in.cmd == CMD_PATTERN) && (w_len_eff != '0) && (w_len_eff < MAX_LEN);
        w_txt_walk = (i_in.cmd == CMD_TEXT) && !r_run_done && (r_len != '0)
                     && (r_offset < i_max_scan);
        w_imm_emit = (i_in.cmd == CMD_TEXT) && !r_run_done && !w_txt_walk
                     && ((r_len == '0) || i_in.last);
        w_eq        = (i_pat_rd_data == r_byte);
        w_mis       = (r_idx != '0) && !w_eq;
        w_inc       = LW'(r_idx) + LW'(w_eq);
        w_hit       = (w_inc >= r_len);
        w_walk_emit = (r_cmd == CMD_TEXT) && (w_hit || r_last);
        w_pos       = r_offset + 32'd1 - 32'(r_len);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (w_pat_walk || w_txt_walk) begin
                        n_state = S_WALK;
                    end else if (w_imm_emit && !i_slot_free) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_WALK: begin
                if (!w_mis) begin
                    n_state = (w_walk_emit && !i_slot_free) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_len      = r_len;
        n_border   = r_border;
        n_matched  = r_matched;
        n_offset   = r_offset;
        n_run_done = r_run_done;
        n_ovf      = r_ovf;
        n_open     = r_open;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_byte     = r_byte;
        n_last     = r_last;
        n_res      = r_res;

        o_rd_en        = 1'b0;
        o_pat_rd_addr  = w_i0;
        o_fail_rd_addr = w_i0 - AW'(1);
        o_wr_en        = 1'b0;
        o_wr_addr      = r_len[AW-1:0];
        o_wr_pat       = r_byte;
        o_wr_fail      = w_inc[AW-1:0];
        o_res_valid    = 1'b0;
        o_res          = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.cmd;
                    n_byte  = i_in.data_byte;
                    n_last  = i_in.last;
                    n_idx   = w_i0;
                    o_rd_en = 1'b1;
                    if (i_in.cmd == CMD_PATTERN) begin
                        // first beat of a new pattern drops the old one and the run
                        if (!r_open) begin
                            n_len      = '0;
                            n_border   = '0;
                            n_ovf      = 1'b0;
                            n_matched  = '0;
                            n_offset   = '0;
                            n_run_done = 1'b0;
                        end
                        n_open = !i_in.last;
                        if (w_len_eff == '0) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = '0;
                            o_wr_pat  = i_in.data_byte;
                            o_wr_fail = '0;
                            n_len     = LW'(1);
                            n_border  = '0;
                        end else if (w_len_eff >= MAX_LEN) begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_open = 1'b0;
                        if (w_imm_emit) begin
                            o_res.found            = (r_len == '0);
                            o_res.match_position   = '0;
                            o_res.pattern_overflow = r_ovf;
                            o_res_valid            = i_slot_free;
                            n_res                  = o_res;
                        end
                        if (!r_run_done && (r_len == '0)) begin
                            n_run_done = 1'b1;
                        end
                        if (i_in.last && !w_txt_walk) begin
                            n_matched  = '0;
                            n_offset   = '0;
                            n_run_done = 1'b0;
                        end
                    end
                end
            end
            S_WALK: begin
                o_pat_rd_addr  = i_fail_rd_data;
                o_fail_rd_addr = i_fail_rd_data - AW'(1);
                if (w_mis) begin
                    // follow the failure link and read again
                    o_rd_en = 1'b1;
                    n_idx   = i_fail_rd_data;
                end else if (r_cmd == CMD_PATTERN) begin
                    o_wr_en  = 1'b1;
                    n_border = w_inc[AW-1:0];
                    n_len    = r_len + LW'(1);
                end else begin
                    n_matched  = w_hit ? '0 : w_inc[AW-1:0];
                    n_offset   = r_offset + 32'd1;
                    n_run_done = w_hit;
                    o_res.found            = w_hit;
                    o_res.match_position   = w_hit ? w_pos : '0;
                    o_res.pattern_overflow = r_ovf;
                    o_res_valid            = w_walk_emit && i_slot_free;
                    n_res                  = o_res;
                    if (r_last) begin
                        n_matched  = '0;
                        n_offset   = '0;
                        n_run_done = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                o_res_valid = i_slot_free;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_border   <= '0;
            r_matched  <= '0;
            r_offset   <= '0;
            r_run_done <= 1'b0;
            r_ovf      <= 1'b0;
            r_open     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_border   <= n_border;
            r_matched  <= n_matched;
            r_offset   <= n_offset;
            r_run_done <= n_run_done;
            r_ovf      <= n_ovf;
            r_open     <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cmd  <= n_cmd;
        r_byte <= n_byte;
        r_last <= n_last;
        r_res  <= n_res;
    end

endmodule

// File: rtl/core/kmp_stream_matcher_core.sv
// Streaming Knuth-Morris-Pratt matcher.
// Input channel i_in: one beat per byte. cmd = 0 appends a pattern byte and
// extends the failure table; last = 1 closes the pattern. cmd = 1 is a text
// byte; last = 1 ends the text run. The next pattern byte after a closed
// pattern starts a fresh pattern. Bytes beyond MAX_PATTERN are dropped and
// flagged in pattern_overflow.
// Output channel o_out: at most one beat per run, the offset of the first
// match (found = 1) or not-found on the run's last byte.
// Config channel i_cfg: writes max_scan, the most text bytes examined per
// run; write it only while the block is idle.
// Timing: a beat that walks the table is taken in S_IDLE and then steps
// through S_WALK, one more step per failure link followed; each step is one
// read of the pattern and failure RAMs, whose read data is registered.
// Beats with no walk finish in S_IDLE, unless their result waits in S_EMIT.
// Reset clears the pattern length, run state and overflow flag and sets
// max_scan to all ones; RAM contents are left as they are.
// A stalled receiver holds the output register; the block keeps taking
// beats until a second result is ready, then holds until the slot frees.
module kmp_stream_matcher_core
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmp_in_if.sink     i_in,
    kmp_out_if.source  o_out,
    kmp_cfg_if.sink    i_cfg
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [31:0]   r_max_scan;
    logic          r_out_valid;
    t_result       r_out;

    logic          w_slot_free;
    logic          w_res_valid;
    t_result       w_res;
    logic          w_rd_en;
    logic [AW-1:0] w_pat_rd_addr;
    logic [7:0]    w_pat_rd_data;
    logic [AW-1:0] w_fail_rd_addr;
    logic [AW-1:0] w_fail_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_pat;
    logic [AW-1:0] w_wr_fail;

    // Config writes are always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_scan <= SCAN_RESET;
        end else if (i_cfg.valid) begin
            r_max_scan <= i_cfg.data;
        end
    end

    // Output register: load when empty or being drained this cycle
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.found            = r_out.found;
    assign o_out.match_position   = r_out.match_position;
    assign o_out.pattern_overflow = r_out.pattern_overflow;

    kmp_engine #(
        .MAX_PATTERN (MAX_PATTERN),
        .AW          (AW)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_max_scan     (r_max_scan),
        .i_slot_free    (w_slot_free),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .o_rd_en        (w_rd_en),
        .o_pat_rd_addr  (w_pat_rd_addr),
        .i_pat_rd_data  (w_pat_rd_data),
        .o_fail_rd_addr (w_fail_rd_addr),
        .i_fail_rd_data (w_fail_rd_data),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_pat       (w_wr_pat),
        .o_wr_fail      (w_wr_fail)
    );

    // Pattern bytes
    kmp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_pat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_pat),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_pat_rd_addr),
        .o_rd_data (w_pat_rd_data)
    );

    // Failure links: longest proper border of each prefix
    kmp_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_fail_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_fail),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_fail_rd_addr),
        .o_rd_data (w_fail_rd_data)
    );

endmodule

// File: verif/kmp_stream_matcher_core_tb.sv
`timescale 1ns / 1ps

module kmp_stream_matcher_core_tb;
    import kmp_pkg::*;

    localparam int MAX_PAT      = 32;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_CYCLES = 400;
    localparam int PHASE_BEATS  = 200;
    localparam int NUM_PHASES   = 7;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       last;
    } t_stream_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kmp_in_if  in_bus ();
    kmp_out_if out_bus ();
    kmp_cfg_if cfg_bus ();

    kmp_stream_matcher_core #(
        .MAX_PATTERN (MAX_PAT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Matcher shadow: pattern, failure links and run state at testbench widths
    // ------------------------------------------------------------------
    logic [7:0]  sh_pat [MAX_PAT];
    logic [5:0]  sh_link [MAX_PAT];
    logic [5:0]  sh_len      = '0;
    logic [5:0]  sh_border   = '0;
    logic [5:0]  sh_matched  = '0;
    logic [31:0] sh_offset   = '0;
    logic [31:0] sh_scan_max = SCAN_RESET;
    logic        sh_done     = 1'b0;
    logic        sh_ovf      = 1'b0;
    logic        sh_open     = 1'b0;

    t_result      match_reports [$];   // reports still owed by the block
    t_stream_beat byte_queue [$];      // beats waiting to be offered

    int fail_count      = 0;
    int beats_accepted  = 0;
    int reports_checked = 0;
    int scan_writes     = 0;
    int phase_beats     = 0;

    // Drop the run state: offset, matched count and done flag.
    function automatic void restart_text_run();
        sh_matched = '0;
        sh_offset  = '0;
        sh_done    = 1'b0;
    endfunction

    // Advance the shadow by one accepted beat; queue the report it causes.
    function automatic void kmp_predict(input t_stream_beat b);
        logic [5:0] idx;
        logic       emit;
        t_result    rep;
        emit = 1'b0;
        rep  = '0;
        if (b.cmd == CMD_PATTERN) begin
            // A byte after a closed pattern starts a fresh one.
            if (!sh_open) begin
                sh_len    = '0;
                sh_border = '0;
                sh_ovf    = 1'b0;
                sh_open   = 1'b1;
                restart_text_run();
            end
            if (sh_len < MAX_PAT) begin
                if (sh_len == 0) begin
                    sh_border = '0;
                end else begin
                    while (sh_border > 0 && sh_pat[sh_border] != b.data_byte)
                        sh_border = sh_link[sh_border - 1];
                    if (sh_pat[sh_border] == b.data_byte)
                        sh_border = sh_border + 6'd1;
                end
                sh_pat[sh_len]  = b.data_byte;
                sh_link[sh_len] = sh_border;
                sh_len          = sh_len + 6'd1;
            end else begin
                // Drop bytes past capacity, remember the overflow.
                sh_ovf = 1'b1;
            end
            if (b.last)
                sh_open = 1'b0;
        end else begin
            sh_open = 1'b0;
            if (!sh_done) begin
                if (sh_len == 0) begin
                    // Empty pattern hits at the first byte of the run.
                    emit      = 1'b1;
                    rep.found = 1'b1;
                    sh_done   = 1'b1;
                end else if (sh_offset < sh_scan_max) begin
                    idx = sh_matched;
                    while (idx > 0 && sh_pat[idx] != b.data_byte)
                        idx = sh_link[idx - 1];
                    if (sh_pat[idx] == b.data_byte)
                        idx = idx + 6'd1;
                    if (idx >= sh_len) begin
                        emit               = 1'b1;
                        rep.found          = 1'b1;
                        rep.match_position = sh_offset + 32'd1 - {26'd0, sh_len};
                        sh_done            = 1'b1;
                        idx                = '0;
                    end
                    sh_matched = idx;
                    sh_offset  = sh_offset + 32'd1;
                end
                if (b.last && !sh_done) begin
                    emit               = 1'b1;
                    rep.found          = 1'b0;
                    rep.match_position = '0;
                end
            end
            if (b.last)
                restart_text_run();
        end
        if (emit) begin
            rep.pattern_overflow = sh_ovf;
            match_reports.push_back(rep);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Gap length after a beat: mostly none or short, a few long, and
    // now and then a burst of back-to-back beats.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued beats on the input channel
    // ------------------------------------------------------------------
    t_stream_beat drive_beat = '0;
    int           send_gap   = 0;
    int           send_burst = 0;

    always @(posedge i_clk) begin : drive_proc
        logic         nxt_valid;
        t_stream_beat nxt;
        if (!i_rst_n) begin
            in_bus.valid     <= 1'b0;
            in_bus.cmd       <= CMD_PATTERN;
            in_bus.data_byte <= 8'h00;
            in_bus.last      <= 1'b0;
        end else begin
            nxt_valid = in_bus.valid;
            nxt       = drive_beat;
            if (in_bus.valid && in_bus.ready) begin
                kmp_predict(drive_beat);
                beats_accepted++;
                nxt_valid = 1'b0;
            end
            // Hold the current beat until taken; otherwise wait out the
            // gap, then pull the next one.
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (byte_queue.size() > 0) begin
                    nxt       = byte_queue.pop_front();
                    nxt_valid = 1'b1;
                    send_gap  = pick_gap(send_burst);
                end
            end
            drive_beat        = nxt;
            in_bus.valid     <= nxt_valid;
            in_bus.cmd       <= nxt.cmd;
            in_bus.data_byte <= nxt.data_byte;
            in_bus.last      <= nxt.last;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take reports, compare with the oldest prediction
    // ------------------------------------------------------------------
    logic hold_off   = 1'b0;
    int   recv_gap   = 0;
    int   recv_burst = 0;

    task automatic check_report();
        t_result want;
        reports_checked++;
        if (match_reports.size() == 0) begin
            report_mismatch("report with nothing predicted");
        end else begin
            want = match_reports.pop_front();
            if (out_bus.found !== want.found)
                report_mismatch($sformatf("found %0b, predicted %0b",
                                          out_bus.found, want.found));
            if (out_bus.match_position !== want.match_position)
                report_mismatch($sformatf("match_position %0d, predicted %0d",
                                          out_bus.match_position, want.match_position));
            if (out_bus.pattern_overflow !== want.pattern_overflow)
                report_mismatch($sformatf("pattern_overflow %0b, predicted %0b",
                                          out_bus.pattern_overflow,
                                          want.pattern_overflow));
        end
    endtask

    always @(posedge i_clk) begin : watch_proc
        logic rdy;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                check_report();
                recv_gap = pick_gap(recv_burst);
            end
            if (hold_off) begin
                rdy = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_bus.ready <= rdy;
        end
    end

    // Long receiver hold-off while the sender keeps offering beats, so
    // the output slot fills and the block backs up into its input.
    logic stall_arm = 1'b0;

    initial begin : stall_proc
        int k;
        wait (stall_arm);
        for (k = 0; k < 2; k++) begin
            repeat ($urandom_range(40, 160)) @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (STALL_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [7:0] alpha [4];
    int         alpha_n = 1;
    logic [7:0] cur_pat [$];

    task automatic push_beat(input logic cmd, input logic [7:0] data, input logic last);
        t_stream_beat b;
        b.cmd       = cmd;
        b.data_byte = data;
        b.last      = last;
        byte_queue.push_back(b);
        phase_beats++;
    endtask

    function automatic logic [7:0] pick_char();
        return alpha[$urandom_range(0, alpha_n - 1)];
    endfunction

    task automatic add_pattern(input int len, input bit close);
        int k;
        logic [7:0] c;
        cur_pat.delete();
        for (k = 0; k < len; k++) begin
            c = pick_char();
            cur_pat.push_back(c);
            push_beat(CMD_PATTERN, c, close && (k == len - 1));
        end
    endtask

    // Build a text run from the alphabet, optionally with the stored
    // prefix of the current pattern placed inside it.
    task automatic add_text_run(input int pre, input int post, input bit embed,
                                input bit close);
        logic [7:0] run [$];
        int k;
        int plen;
        for (k = 0; k < pre; k++)
            run.push_back(pick_char());
        if (embed && cur_pat.size() > 0) begin
            plen = (cur_pat.size() > MAX_PAT) ? MAX_PAT : cur_pat.size();
            for (k = 0; k < plen; k++)
                run.push_back(cur_pat[k]);
        end
        for (k = 0; k < post; k++)
            run.push_back(pick_char());
        if (run.size() == 0)
            run.push_back(pick_char());
        for (k = 0; k < run.size(); k++)
            push_beat(CMD_TEXT, run[k], close && (k == run.size() - 1));
    endtask

    task automatic add_random_sequence();
        int r;
        int len;
        int k;
        int runs;
        alpha_n = $urandom_range(1, 4);
        for (k = 0; k < 4; k++)
            alpha[k] = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 75) begin
            // Well-formed: one closed pattern, then a few closed runs.
            k = $urandom_range(0, 99);
            if (k < 70)
                len = $urandom_range(1, 5);
            else if (k < 93)
                len = $urandom_range(6, MAX_PAT);
            else
                len = $urandom_range(MAX_PAT + 1, MAX_PAT + 8);
            add_pattern(len, 1'b1);
            runs = $urandom_range(1, 4);
            for (k = 0; k < runs; k++)
                add_text_run($urandom_range(0, 10), $urandom_range(0, 10),
                             $urandom_range(0, 99) < 60, 1'b1);
        end else if (r < 85) begin
            // Pattern left open, closed by the text that follows.
            add_pattern($urandom_range(1, 6), 1'b0);
            add_text_run($urandom_range(0, 6), $urandom_range(0, 6), 1'b1, 1'b1);
        end else if (r < 93) begin
            // Run left open; whatever comes next continues or cuts it.
            add_text_run($urandom_range(0, 6), $urandom_range(1, 6),
                         1'($urandom_range(0, 1)), 1'b0);
        end else begin
            // Noise: every field random.
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++)
                push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until every beat is taken and every report has come back, then
    // give the block time to finish a walk that produces no report.
    task automatic wait_drained();
        while (byte_queue.size() > 0 || in_bus.valid || match_reports.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scan_limit(input logic [31:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge i_clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sh_scan_max = value;
        scan_writes++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stim_proc
        logic [31:0] limits [NUM_PHASES];
        int ph;
        in_bus.valid     = 1'b0;
        in_bus.cmd       = CMD_PATTERN;
        in_bus.data_byte = 8'h00;
        in_bus.last      = 1'b0;
        out_bus.ready    = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern after reset: first byte of each run hits at 0,
        // later bytes of that run stay silent.
        push_beat(CMD_TEXT, 8'hFF, 1'b0);
        push_beat(CMD_TEXT, 8'h00, 1'b1);
        push_beat(CMD_TEXT, 8'h5A, 1'b1);
        // Extreme byte values; after the hit the rest of the run is silent.
        push_beat(CMD_PATTERN, 8'h00, 1'b0);
        push_beat(CMD_PATTERN, 8'hFF, 1'b1);
        push_beat(CMD_TEXT, 8'hFF, 1'b0);
        push_beat(CMD_TEXT, 8'h00, 1'b0);
        push_beat(CMD_TEXT, 8'hFF, 1'b0);
        push_beat(CMD_TEXT, 8'h00, 1'b1);
        // Run with no hit reports not-found on its last byte.
        push_beat(CMD_TEXT, 8'h12, 1'b0);
        push_beat(CMD_TEXT, 8'h34, 1'b1);
        // Mismatch that follows a failure link: "aab" in "aaab".
        push_beat(CMD_PATTERN, 8'h61, 1'b0);
        push_beat(CMD_PATTERN, 8'h61, 1'b0);
        push_beat(CMD_PATTERN, 8'h62, 1'b1);
        push_beat(CMD_TEXT, 8'h61, 1'b0);
        push_beat(CMD_TEXT, 8'h61, 1'b0);
        push_beat(CMD_TEXT, 8'h61, 1'b0);
        push_beat(CMD_TEXT, 8'h62, 1'b1);
        // Pattern closed by a text byte, then a fresh pattern.
        push_beat(CMD_PATTERN, 8'h71, 1'b0);
        push_beat(CMD_TEXT, 8'h71, 1'b1);
        push_beat(CMD_PATTERN, 8'h7A, 1'b1);
        push_beat(CMD_TEXT, 8'h79, 1'b0);
        push_beat(CMD_TEXT, 8'h7A, 1'b1);
        // New pattern mid-run clears the run offset.
        push_beat(CMD_TEXT, 8'h61, 1'b0);
        push_beat(CMD_PATTERN, 8'h62, 1'b0);
        push_beat(CMD_PATTERN, 8'h63, 1'b1);
        push_beat(CMD_TEXT, 8'h62, 1'b0);
        push_beat(CMD_TEXT, 8'h63, 1'b1);
        wait_drained();

        // Scan limit settings: both extremes, tiny limits and random ones.
        limits[0] = SCAN_RESET;
        limits[1] = 32'h0000_0000;
        limits[2] = 32'h0000_0001;
        limits[3] = 32'h0000_0003;
        limits[4] = $urandom_range(2, 16);
        limits[5] = $urandom() | 32'h8000_0000;
        limits[6] = SCAN_RESET;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_scan_limit(limits[ph]);
            phase_beats = 0;
            if (ph == 0)
                stall_arm = 1'b1;
            while (phase_beats < PHASE_BEATS)
                add_random_sequence();
            wait_drained();
        end

        if (match_reports.size() != 0)
            report_mismatch($sformatf("%0d predicted reports never came",
                                      match_reports.size()));

        $display("Run covered %0d input beats and %0d match reports",
                 beats_accepted, reports_checked);
        $display("over %0d scan limit writes, with receiver hold-off.", scan_writes);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog_proc
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/kmp_pkg.sv
rtl/core/kmp_if.sv
rtl/core/kmp_ram.sv
rtl/core/kmp_engine.sv
rtl/core/kmp_stream_matcher_core.sv
verif/kmp_stream_matcher_core_tb.sv
